[src/tvp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tvp_pkg;

  localparam int TIME_W  = 16;            // elapsed time and total time
  localparam int DATA_W  = 32;            // Q8.24 words
  localparam int DEN_W   = 31;            // divisor width, 20000*T < 2^31
  localparam int DIV_QW  = 34;            // quotient bits per divide
  localparam int DIV_LAT = DIV_QW + 1;    // bit stages plus rounding stage
  localparam int RES_W   = DIV_QW + 2;    // signed rounded quotient
  localparam int E_W     = 20;            // 10*t
  localparam int NP_W    = 40;            // position numerator
  localparam int NP_HALF = NP_W / 2;
  localparam int NV_W    = 17;            // velocity numerator
  localparam int NA_W    = 14;            // acceleration numerator
  localparam int POS_NUM_W = DATA_W + NP_W;
  localparam int VEL_NUM_W = DATA_W + NV_W;
  localparam int ACC_NUM_W = DATA_W + NA_W;
  localparam int POS_SCALE = 20000;
  localparam int ACC_SCALE = 10000;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    PH_RAMP_UP   = 2'd0,
    PH_CRUISE    = 2'd1,
    PH_RAMP_DOWN = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_TIME = 3'd0,
    CFG_START_X    = 3'd1,
    CFG_START_Y    = 3'd2,
    CFG_START_Z    = 3'd3,
    CFG_GOAL_X     = 3'd4,
    CFG_GOAL_Y     = 3'd5,
    CFG_GOAL_Z     = 3'd6
  } cfg_idx_t;

endpackage
`default_nettype wire

[src/tvp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divide of a magnitude by den, one quotient bit per
// stage, rounded half away from zero, sign applied at the end.
module tvp_div import tvp_pkg::*; #(
  parameter int NUM_W = POS_NUM_W
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [NUM_W-1:0]        num,
  input  wire logic [DEN_W-1:0]        den,
  input  wire logic                    neg,
  output logic signed [RES_W-1:0]      res
);

  localparam int HW = NUM_W - DIV_QW;

  logic [HW+DEN_W-1:0] hi_ext, den_ext;
  logic                ovf0;

  logic [DEN_W-1:0]  rem_r [DIV_QW];
  logic [DIV_QW-1:0] lo_r  [DIV_QW];
  logic [DIV_QW-1:0] q_r   [DIV_QW];
  logic              neg_r [DIV_QW];
  logic              ovf_r [DIV_QW];

  logic [DEN_W-1:0]  rem_in [DIV_QW];
  logic [DIV_QW-1:0] lo_in  [DIV_QW];
  logic [DIV_QW-1:0] q_in   [DIV_QW];
  logic              neg_in [DIV_QW];
  logic              ovf_in [DIV_QW];

  logic               rnd;
  logic [DIV_QW:0]    mag;
  logic [RES_W-1:0]   res_nxt;
  logic signed [RES_W-1:0] res_r;

  // quotient would not fit in DIV_QW bits: clamp
  assign hi_ext  = {{DEN_W{1'b0}}, num[NUM_W-1:DIV_QW]};
  assign den_ext = {{HW{1'b0}}, den};
  assign ovf0    = hi_ext >= den_ext;

  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in[k] = hi_ext[DEN_W-1:0];
      assign lo_in[k]  = num[DIV_QW-1:0];
      assign q_in[k]   = '0;
      assign neg_in[k] = neg;
      assign ovf_in[k] = ovf0;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign lo_in[k]  = lo_r[k-1];
      assign q_in[k]   = q_r[k-1];
      assign neg_in[k] = neg_r[k-1];
      assign ovf_in[k] = ovf_r[k-1];
    end

    assign trial = {rem_in[k], lo_in[k][DIV_QW-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_r[k]  <= {lo_in[k][DIV_QW-2:0], 1'b0};
        q_r[k]   <= {q_in[k][DIV_QW-2:0], ge};
        neg_r[k] <= neg_in[k];
        ovf_r[k] <= ovf_in[k];
      end
    end
  end

  always_comb begin
    rnd = {rem_r[DIV_QW-1], 1'b0} >= {1'b0, den};
    if (ovf_r[DIV_QW-1]) begin
      mag = {1'b1, {DIV_QW{1'b0}}};
    end else begin
      mag = {1'b0, q_r[DIV_QW-1]} + {{DIV_QW{1'b0}}, rnd};
    end
    res_nxt = neg_r[DIV_QW-1] ? (RES_W)'(-{1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[src/trapezoidal_velocity_profile_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Word
// in_       sink       in_valid / in_stall    elapsed time + 3 cruise velocities
// out_      source     out_valid / out_stall  3 pos, 3 vel, 3 acc, phase
// cfg_      sink       cfg_valid / cfg_ready  register index + 32-bit data
//
// One word per cycle sustained while no stalled output word is held; pipeline:
// 5 front stages, 34 divide bit stages, rounding stage, output register.
// Synchronous active-low reset clears valid bits, start and goal; T gets 1000.
// A held output word with out_stall freezes the whole pipeline; in_stall
// follows. cfg_ready is always high; write only while idle.
module trapezoidal_velocity_profile_top import tvp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TIME_W-1:0]     in_elapsed_time,
  input  wire logic signed [DATA_W-1:0] in_cruise_vel_x,
  input  wire logic signed [DATA_W-1:0] in_cruise_vel_y,
  input  wire logic signed [DATA_W-1:0] in_cruise_vel_z,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [DATA_W-1:0]   out_pos_x,
  output logic signed [DATA_W-1:0]   out_pos_y,
  output logic signed [DATA_W-1:0]   out_pos_z,
  output logic signed [DATA_W-1:0]   out_vel_x,
  output logic signed [DATA_W-1:0]   out_vel_y,
  output logic signed [DATA_W-1:0]   out_vel_z,
  output logic signed [DATA_W-1:0]   out_acc_x,
  output logic signed [DATA_W-1:0]   out_acc_y,
  output logic signed [DATA_W-1:0]   out_acc_z,
  output logic [1:0]                 out_phase,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0]     cfg_data
);

  // clamp to signed 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic signed [RES_W+1:0] x);
    logic signed [RES_W+1:0] hi_lim, lo_lim;
    hi_lim = (RES_W+2)'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo_lim = -hi_lim - (RES_W+2)'(1);
    if (x > hi_lim)      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    else if (x < lo_lim) sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    else                 sat32 = x[DATA_W-1:0];
  endfunction

  // ---- configuration ----
  logic [TIME_W-1:0] total_time_r;
  logic [DATA_W-1:0] start_r [3];
  logic [DATA_W-1:0] goal_r  [3];
  logic [DEN_W-1:0]  den_pos_r;   // 20000*T
  logic [DEN_W-1:0]  den_t;
  logic [E_W-1:0]    nine_t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_time_r <= TIME_W'(1000);
      for (int a = 0; a < 3; a++) begin
        start_r[a] <= '0;
        goal_r[a]  <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_TIME: total_time_r <= cfg_data[TIME_W-1:0];
        CFG_START_X:    start_r[0]   <= cfg_data;
        CFG_START_Y:    start_r[1]   <= cfg_data;
        CFG_START_Z:    start_r[2]   <= cfg_data;
        CFG_GOAL_X:     goal_r[0]    <= cfg_data;
        CFG_GOAL_Y:     goal_r[1]    <= cfg_data;
        CFG_GOAL_Z:     goal_r[2]    <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    den_pos_r <= DEN_W'(32'(total_time_r) * 32'(POS_SCALE));
  end

  assign den_t  = DEN_W'(total_time_r);
  assign nine_t = E_W'({total_time_r, 3'b000}) + E_W'(total_time_r);

  // ---- flow control ----
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---- S1: phase, e, d, magnitudes ----
  logic [E_W-1:0] e_nxt, d_nxt;
  phase_t         ph_nxt;
  logic [E_W-1:0] e1_r, d1_r;
  phase_t         ph1_r, ph2_r, ph3_r, ph4_r, ph5_r;
  logic           v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [DATA_W-1:0] vin [3];
  logic [DATA_W-1:0] m1_r [3], m2_r [3], m3_r [3];
  logic              n1_r [3], n2_r [3], n3_r [3], n4_r [3], n5_r [3];

  assign vin[0] = in_cruise_vel_x;
  assign vin[1] = in_cruise_vel_y;
  assign vin[2] = in_cruise_vel_z;

  always_comb begin
    e_nxt = E_W'({in_elapsed_time, 3'b000}) + E_W'({in_elapsed_time, 1'b0});
    d_nxt = e_nxt - nine_t;
    if (e_nxt < E_W'(total_time_r))      ph_nxt = PH_RAMP_UP;
    else if (e_nxt < nine_t)             ph_nxt = PH_CRUISE;
    else if (in_elapsed_time < total_time_r) ph_nxt = PH_RAMP_DOWN;
    else                                 ph_nxt = PH_DONE;
  end

  // ---- S2: products of e, d and T ----
  logic [2*E_W-1:0]      ee2_r, dd2_r;
  logic [E_W+TIME_W-1:0] et2_r, dt2_r;
  logic [2*TIME_W-1:0]   tt2_r;
  logic [E_W-1:0]        e2_r, d2_r;

  // ---- S3: numerators ----
  logic [NP_W-1:0] np_nxt, np3_r;
  logic [NV_W-1:0] nv_nxt, nv3_r;
  logic [NA_W-1:0] na_nxt, na3_r;

  always_comb begin
    np_nxt = '0;
    nv_nxt = '0;
    na_nxt = '0;
    case (ph2_r)
      PH_RAMP_UP: begin
        np_nxt = NP_W'(ee2_r);
        nv_nxt = e2_r[NV_W-1:0];
        na_nxt = NA_W'(ACC_SCALE);
      end
      PH_CRUISE: begin
        np_nxt = NP_W'({et2_r, 1'b0}) - NP_W'(tt2_r);
        nv_nxt = NV_W'(total_time_r);
      end
      PH_RAMP_DOWN: begin
        np_nxt = NP_W'({tt2_r, 4'b0000}) + NP_W'(tt2_r) + NP_W'({dt2_r, 1'b0})
                 - NP_W'(dd2_r);
        nv_nxt = NV_W'(total_time_r) - d2_r[NV_W-1:0];
        na_nxt = NA_W'(ACC_SCALE);
      end
      default: ;
    endcase
  end

  // ---- S4: partial products, S5: position sum ----
  logic [DATA_W+NP_HALF-1:0] pl4_r [3], ph4p_r [3];
  logic [VEL_NUM_W-1:0]      pv4_r [3], pv5_r [3];
  logic [ACC_NUM_W-1:0]      pa4_r [3], pa5_r [3];
  logic                      an4_r [3], an5_r [3];
  logic [POS_NUM_W-1:0]      pp5_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // S1
      e1_r <= e_nxt;
      d1_r <= d_nxt;
      ph1_r <= ph_nxt;
      for (int a = 0; a < 3; a++) begin
        n1_r[a] <= vin[a][DATA_W-1];
        m1_r[a] <= vin[a][DATA_W-1] ? DATA_W'(-vin[a]) : vin[a];
      end
      // S2
      ee2_r <= e1_r * e1_r;
      dd2_r <= d1_r * d1_r;
      et2_r <= e1_r * total_time_r;
      dt2_r <= d1_r * total_time_r;
      tt2_r <= total_time_r * total_time_r;
      e2_r  <= e1_r;
      d2_r  <= d1_r;
      ph2_r <= ph1_r;
      // S3
      np3_r <= np_nxt;
      nv3_r <= nv_nxt;
      na3_r <= na_nxt;
      ph3_r <= ph2_r;
      // S4
      ph4_r <= ph3_r;
      // S5
      ph5_r <= ph4_r;
      for (int a = 0; a < 3; a++) begin
        m2_r[a] <= m1_r[a];
        n2_r[a] <= n1_r[a];
        m3_r[a] <= m2_r[a];
        n3_r[a] <= n2_r[a];
        pl4_r[a]  <= m3_r[a] * np3_r[NP_HALF-1:0];
        ph4p_r[a] <= m3_r[a] * np3_r[NP_W-1:NP_HALF];
        pv4_r[a]  <= m3_r[a] * nv3_r;
        pa4_r[a]  <= m3_r[a] * na3_r;
        n4_r[a]   <= n3_r[a];
        an4_r[a]  <= n3_r[a] ^ (ph3_r == PH_RAMP_DOWN);
        pp5_r[a]  <= POS_NUM_W'(pl4_r[a]) + POS_NUM_W'({ph4p_r[a], {NP_HALF{1'b0}}});
        pv5_r[a]  <= pv4_r[a];
        pa5_r[a]  <= pa4_r[a];
        n5_r[a]   <= n4_r[a];
        an5_r[a]  <= an4_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // ---- dividers, nine lanes ----
  logic signed [RES_W-1:0] rp [3], rv [3], ra [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tvp_div #(.NUM_W(POS_NUM_W)) u_div_pos (
      .clk(clk), .en(en), .num(pp5_r[a]), .den(den_pos_r), .neg(n5_r[a]), .res(rp[a])
    );
    tvp_div #(.NUM_W(VEL_NUM_W)) u_div_vel (
      .clk(clk), .en(en), .num(pv5_r[a]), .den(den_t), .neg(n5_r[a]), .res(rv[a])
    );
    tvp_div #(.NUM_W(ACC_NUM_W)) u_div_acc (
      .clk(clk), .en(en), .num(pa5_r[a]), .den(den_t), .neg(an5_r[a]), .res(ra[a])
    );
  end

  // phase and valid ride alongside the dividers
  phase_t ph_dly_r [DIV_LAT];
  logic   v_dly_r  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_dly_r[0] <= ph5_r;
      for (int k = 1; k < DIV_LAT; k++) ph_dly_r[k] <= ph_dly_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) v_dly_r[k] <= 1'b0;
    end else if (en) begin
      v_dly_r[0] <= v5_r;
      for (int k = 1; k < DIV_LAT; k++) v_dly_r[k] <= v_dly_r[k-1];
    end
  end

  // ---- output register ----
  logic [DATA_W-1:0] pos_nxt [3], vel_nxt [3], acc_nxt [3];
  logic [DATA_W-1:0] pos_r [3], vel_r [3], acc_r [3];
  phase_t            phase_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (ph_dly_r[DIV_LAT-1] == PH_DONE) begin
        pos_nxt[a] = goal_r[a];
        vel_nxt[a] = '0;
        acc_nxt[a] = '0;
      end else begin
        pos_nxt[a] = sat32((RES_W+2)'(signed'(start_r[a])) + (RES_W+2)'(rp[a]));
        vel_nxt[a] = sat32((RES_W+2)'(rv[a]));
        acc_nxt[a] = sat32((RES_W+2)'(ra[a]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_dly_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= ph_dly_r[DIV_LAT-1];
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= pos_nxt[a];
        vel_r[a] <= vel_nxt[a];
        acc_r[a] <= acc_nxt[a];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_phase = phase_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_vel_x = vel_r[0];
  assign out_vel_y = vel_r[1];
  assign out_vel_z = vel_r[2];
  assign out_acc_x = acc_r[0];
  assign out_acc_y = acc_r[1];
  assign out_acc_z = acc_r[2];

endmodule
`default_nettype wire

[src/tvp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module tvp_chk import tvp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] out_pos_x,
  input wire logic [DATA_W-1:0] out_vel_x,
  input wire logic [DATA_W-1:0] out_vel_y,
  input wire logic [DATA_W-1:0] out_vel_z,
  input wire logic [DATA_W-1:0] out_acc_x,
  input wire logic [DATA_W-1:0] out_acc_y,
  input wire logic [DATA_W-1:0] out_acc_z,
  input wire logic [1:0]        out_phase
);

  // nothing comes out of reset valid
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_phase))
    else $error("stalled word changed");

  // finished: at rest
  a_done_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_DONE |->
      out_vel_x == '0 && out_vel_y == '0 && out_vel_z == '0 &&
      out_acc_x == '0 && out_acc_y == '0 && out_acc_z == '0)
    else $error("motion in finished phase");

  // cruise: no acceleration
  a_cruise_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_CRUISE |->
      out_acc_x == '0 && out_acc_y == '0 && out_acc_z == '0)
    else $error("acceleration in cruise");

endmodule

bind trapezoidal_velocity_profile_top tvp_chk u_tvp_chk (.*);
`default_nettype wire
